// ----- hw/rtl/rmf_pkg.sv -----
// Shared types, sizes and codes of the first-fit free region table.
// Used by every file under hw/rtl; depends on nothing.
package rmf_pkg;

   localparam int MAX_REGIONS = 16;
   localparam int ADDR_WIDTH  = 32;
   localparam int IDX_W       = $clog2(MAX_REGIONS);
   localparam int CNT_W       = $clog2(MAX_REGIONS + 1);

   localparam logic [1:0] OP_ADD     = 2'd0;
   localparam logic [1:0] OP_EXCLUDE = 2'd1;
   localparam logic [1:0] OP_ALLOC   = 2'd2;
   localparam logic [1:0] OP_LIST    = 2'd3;

   localparam logic [2:0] ST_OK    = 3'd0;
   localparam logic [2:0] ST_BAD   = 3'd1;
   localparam logic [2:0] ST_NOFIT = 3'd2;
   localparam logic [2:0] ST_FULL  = 3'd3;
   localparam logic [2:0] ST_EMPTY = 3'd4;

   typedef logic [ADDR_WIDTH-1:0] addr_type;

   typedef struct packed {
      logic [1:0]  op;
      logic [31:0] base_addr;
      logic [31:0] length;
   } req_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] alloc_addr;
      logic [31:0] entry_base;
      logic [31:0] entry_size;
      logic        last;
   } rsp_type;

   typedef struct packed {
      addr_type start;
      addr_type len;
   } region_type;

   // one command broadcast to every cell of the row
   typedef struct packed {
      logic             wr_en;
      logic [IDX_W-1:0] wr_idx;
      region_type       wr_data;
      logic             ins_en;
      logic [IDX_W-1:0] ins_idx;
      region_type       ins_data;
      logic             rm_en;
      logic [IDX_W-1:0] rm_idx;
   } cell_cmd_type;

   function automatic addr_type to_addr(input logic [31:0] x);
      addr_type r;
      for (int k = 0; k < ADDR_WIDTH; k++) begin
         r[k] = (k < 32) ? x[k] : 1'b0;
      end
      return r;
   endfunction

   function automatic logic [31:0] from_addr(input addr_type x);
      logic [31:0] r;
      for (int k = 0; k < 32; k++) begin
         r[k] = (k < ADDR_WIDTH) ? x[k] : 1'b0;
      end
      return r;
   endfunction

endpackage

// ----- hw/rtl/rmf_cell.sv -----
// One slot of the sorted region row: holds a region and takes its
// neighbor's on insert or remove. Depends on rmf_pkg.
module rmf_cell (
   input  logic                    clock,
   input  rmf_pkg::cell_cmd_type   cmd,
   input  logic [rmf_pkg::IDX_W-1:0] my_idx,
   input  rmf_pkg::region_type     prev,
   input  rmf_pkg::region_type     next,
   output rmf_pkg::region_type     q
);
   import rmf_pkg::*;

   region_type data_ff, data_in;

   always_comb begin
      data_in = data_ff;
      if (cmd.ins_en && my_idx == cmd.ins_idx) begin
         data_in = cmd.ins_data;
      end else if (cmd.ins_en && my_idx > cmd.ins_idx) begin
         data_in = prev;
      end else if (cmd.rm_en && my_idx >= cmd.rm_idx) begin
         data_in = next;
      end else if (cmd.wr_en && my_idx == cmd.wr_idx) begin
         data_in = cmd.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign q = data_ff;

endmodule

// ----- hw/rtl/region_map_first_fit_allocator_top.sv -----
// First-fit free region table: sequencer plus a row of region cells.
// Depends on rmf_pkg and rmf_cell.
//
// Usage: a request (op, base_addr, length) is taken at a clock edge with
// start high and busy low. busy then stays high until the last response.
// Responses appear on rsp_data for one cycle each with rsp_valid high;
// the receiver cannot stall them. Add, exclude and allocate give one
// response, list gives one per stored region (or one empty status), the
// last one marked by rsp_data.last.
// Sequencing: a check state S_CHECK, then the sequencer walks the stored
// regions one per cycle; list sends one region per cycle. The rate is set
// by the single read port of the sequencer onto the cell row; inserts and
// removals shift the row in the same cycle.
// Reset empties the table (count to zero) and idles the sequencer; cell
// contents are not cleared.
module region_map_first_fit_allocator_top (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  rmf_pkg::req_type req_data,
   output logic             rsp_valid,
   output rmf_pkg::rsp_type rsp_data
);
   import rmf_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_CHECK = 3'd1;
   localparam logic [2:0] S_ADD   = 3'd2;
   localparam logic [2:0] S_EXCL  = 3'd3;
   localparam logic [2:0] S_ALLOC = 3'd4;
   localparam logic [2:0] S_LIST  = 3'd5;

   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(MAX_REGIONS);

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] pos_ff, pos_in;
   logic             pos_set_ff, pos_set_in;
   logic [1:0]       op_ff, op_in;
   addr_type         b_ff, b_in, l_ff, l_in, e_ff, e_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_ff, rsp_in;

   cell_cmd_type cmd;
   region_type   cells [MAX_REGIONS];
   region_type   cur;
   addr_type     re;
   logic         hit, keep_lo, keep_hi, bad, at_end;
   logic [CNT_W-1:0] idx_p1, idx_p2;

   genvar g;
   generate
      for (g = 0; g < MAX_REGIONS; g++) begin : g_cell
         rmf_cell u_cell (
            .clock  (clock),
            .cmd    (cmd),
            .my_idx (IDX_W'(g)),
            .prev   (cells[(g == 0) ? 0 : g - 1]),
            .next   (cells[(g == MAX_REGIONS - 1) ? g : g + 1]),
            .q      (cells[g])
         );
      end
   endgenerate

   assign cur     = cells[idx_ff[IDX_W-1:0]];
   assign re      = cur.start + cur.len - addr_type'(1);
   assign hit     = (b_ff <= re) && (cur.start <= e_ff);
   assign keep_lo = b_ff > cur.start;
   assign keep_hi = e_ff < re;
   // zero length, or last address past the top of the address space
   assign bad     = (l_ff == '0) || ((l_ff - addr_type'(1)) > ~b_ff);
   assign at_end  = idx_ff >= count_ff;
   assign idx_p1  = idx_ff + CNT_W'(1);
   assign idx_p2  = idx_ff + CNT_W'(2);

   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      count_in     = count_ff;
      pos_in       = pos_ff;
      pos_set_in   = pos_set_ff;
      op_in        = op_ff;
      b_in         = b_ff;
      l_in         = l_ff;
      e_in         = e_ff;
      rsp_valid_in = 1'b0;
      rsp_in       = '0;
      rsp_in.last  = 1'b1;
      cmd          = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               op_in    = req_data.op;
               b_in     = to_addr(req_data.base_addr);
               l_in     = to_addr(req_data.length);
               e_in     = to_addr(req_data.base_addr) + to_addr(req_data.length)
                          - addr_type'(1);
               idx_in   = '0;
               state_in = S_CHECK;
            end
         end
         S_CHECK: begin
            unique case (op_ff)
               OP_ADD: begin
                  if (bad || count_ff >= FULL_CNT) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = bad ? ST_BAD : ST_FULL;
                     state_in      = S_IDLE;
                  end else begin
                     pos_in     = count_ff;
                     pos_set_in = 1'b0;
                     state_in   = S_ADD;
                  end
               end
               OP_EXCLUDE: begin
                  if (bad) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_BAD;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_EXCL;
                  end
               end
               OP_ALLOC: begin
                  if (l_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_BAD;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_ALLOC;
                  end
               end
               default: begin
                  if (count_ff == '0) begin
                     rsp_valid_in  = 1'b1;
                     rsp_in.status = ST_EMPTY;
                     state_in      = S_IDLE;
                  end else begin
                     state_in = S_LIST;
                  end
               end
            endcase
         end
         S_ADD: begin
            if (at_end) begin
               cmd.ins_en            = 1'b1;
               cmd.ins_idx           = pos_ff[IDX_W-1:0];
               cmd.ins_data.start    = b_ff;
               cmd.ins_data.len      = l_ff;
               count_in              = count_ff + CNT_W'(1);
               rsp_valid_in          = 1'b1;
               rsp_in.status         = ST_OK;
               state_in              = S_IDLE;
            end else if (hit) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_BAD;
               state_in      = S_IDLE;
            end else begin
               if (!pos_set_ff && cur.start > b_ff) begin
                  pos_in     = idx_ff;
                  pos_set_in = 1'b1;
               end
               idx_in = idx_p1;
            end
         end
         S_EXCL: begin
            if (at_end) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_OK;
               state_in      = S_IDLE;
            end else if (!hit) begin
               idx_in = idx_p1;
            end else if (keep_lo && keep_hi) begin
               if (count_ff >= FULL_CNT) begin
                  // lower regions already trimmed stay trimmed
                  rsp_valid_in  = 1'b1;
                  rsp_in.status = ST_FULL;
                  state_in      = S_IDLE;
               end else begin
                  cmd.wr_en          = 1'b1;
                  cmd.wr_idx         = idx_ff[IDX_W-1:0];
                  cmd.wr_data.start  = cur.start;
                  cmd.wr_data.len    = b_ff - cur.start;
                  cmd.ins_en         = 1'b1;
                  cmd.ins_idx        = idx_p1[IDX_W-1:0];
                  cmd.ins_data.start = e_ff + addr_type'(1);
                  cmd.ins_data.len   = re - e_ff;
                  count_in           = count_ff + CNT_W'(1);
                  idx_in             = idx_p2;
               end
            end else if (keep_lo) begin
               cmd.wr_en         = 1'b1;
               cmd.wr_idx        = idx_ff[IDX_W-1:0];
               cmd.wr_data.start = cur.start;
               cmd.wr_data.len   = b_ff - cur.start;
               idx_in            = idx_p1;
            end else if (keep_hi) begin
               cmd.wr_en         = 1'b1;
               cmd.wr_idx        = idx_ff[IDX_W-1:0];
               cmd.wr_data.start = e_ff + addr_type'(1);
               cmd.wr_data.len   = re - e_ff;
               idx_in            = idx_p1;
            end else begin
               cmd.rm_en  = 1'b1;
               cmd.rm_idx = idx_ff[IDX_W-1:0];
               count_in   = count_ff - CNT_W'(1);
            end
         end
         S_ALLOC: begin
            if (at_end) begin
               rsp_valid_in  = 1'b1;
               rsp_in.status = ST_NOFIT;
               state_in      = S_IDLE;
            end else if (cur.len >= l_ff) begin
               if (cur.len == l_ff) begin
                  cmd.rm_en  = 1'b1;
                  cmd.rm_idx = idx_ff[IDX_W-1:0];
                  count_in   = count_ff - CNT_W'(1);
               end else begin
                  cmd.wr_en         = 1'b1;
                  cmd.wr_idx        = idx_ff[IDX_W-1:0];
                  cmd.wr_data.start = cur.start + l_ff;
                  cmd.wr_data.len   = cur.len - l_ff;
               end
               rsp_valid_in      = 1'b1;
               rsp_in.status     = ST_OK;
               rsp_in.alloc_addr = from_addr(cur.start);
               state_in          = S_IDLE;
            end else begin
               idx_in = idx_p1;
            end
         end
         S_LIST: begin
            rsp_valid_in      = 1'b1;
            rsp_in.status     = ST_OK;
            rsp_in.entry_base = from_addr(cur.start);
            rsp_in.entry_size = from_addr(cur.len);
            rsp_in.last       = (idx_p1 == count_ff);
            idx_in            = idx_p1;
            if (idx_p1 == count_ff) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff     <= idx_in;
      pos_ff     <= pos_in;
      pos_set_ff <= pos_set_in;
      op_ff      <= op_in;
      b_ff       <= b_in;
      l_ff       <= l_in;
      e_ff       <= e_in;
      rsp_ff     <= rsp_in;
   end

   assign busy      = state_ff != S_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

// ----- hw/rtl/rmf_checker.sv -----
// Port-level checks of the region table top, bound onto it.
// Depends on rmf_pkg and region_map_first_fit_allocator_top.
module rmf_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input rmf_pkg::req_type req_data,
   input logic             rsp_valid,
   input rmf_pkg::rsp_type rsp_data
);
   import rmf_pkg::*;

   // a taken request always raises busy in the cycle after it is taken
   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("busy not raised after request");

   // the final response frees the block, so no response right after it
   a_gap_after_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |=> !rsp_valid)
      else $error("response directly after last");

   // only a list gives several responses, and all of them are ok
   a_err_is_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status != ST_OK) |-> rsp_data.last)
      else $error("error status not final");

   a_more_means_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.last) |-> busy)
      else $error("block idle with responses pending");

   a_addr_only_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.alloc_addr != '0) |-> rsp_data.status == ST_OK)
      else $error("address granted with error status");

endmodule

bind region_map_first_fit_allocator_top rmf_checker u_rmf_checker (.*);

// ----- tb/region_map_first_fit_allocator_checker.sv -----
// Checker for the first-fit free region table: predicts responses per request.
// Depends on rmf_pkg; instantiated by region_map_first_fit_allocator_top_test.
`timescale 1ns / 100ps
module region_map_first_fit_allocator_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   input  logic             busy,
   input  rmf_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  rmf_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count
);
   import rmf_pkg::*;

   logic [31:0] free_base [MAX_REGIONS];
   logic [31:0] free_len [MAX_REGIONS];
   int          free_count;
   rsp_type     expected_rsp_q[$];

   assign pending_count = expected_rsp_q.size();

   function automatic bit range_invalid(logic [31:0] b, logic [31:0] len);
      return len == 0 || (len - 32'd1) > (32'hFFFF_FFFF - b);
   endfunction

   function automatic void drop_region(int i);
      for (int j = i; j + 1 < free_count; j++) begin
         free_base[j] = free_base[j+1];
         free_len[j] = free_len[j+1];
      end
      free_count--;
   endfunction

   function automatic void put_region(int i, logic [31:0] b, logic [31:0] s);
      for (int j = free_count; j > i; j--) begin
         free_base[j] = free_base[j-1];
         free_len[j] = free_len[j-1];
      end
      free_base[i] = b;
      free_len[i] = s;
      free_count++;
   endfunction

   function automatic logic [2:0] add_region(logic [31:0] b, logic [31:0] len);
      logic [31:0] e, re;
      int pos;
      e = b + len - 1;
      pos = free_count;
      if (range_invalid(b, len)) return ST_BAD;
      if (free_count >= MAX_REGIONS) return ST_FULL;
      for (int i = 0; i < free_count; i++) begin
         re = free_base[i] + free_len[i] - 1;
         if (b <= re && free_base[i] <= e) return ST_BAD;
         if (pos == free_count && free_base[i] > b) pos = i;
      end
      put_region(pos, b, len);
      return ST_OK;
   endfunction

   function automatic logic [2:0] exclude_range(logic [31:0] b, logic [31:0] len);
      logic [31:0] e, rs, re;
      bit keep_lo, keep_hi;
      int i;
      e = b + len - 1;
      i = 0;
      if (range_invalid(b, len)) return ST_BAD;
      while (i < free_count) begin
         rs = free_base[i];
         re = rs + free_len[i] - 1;
         if (!(b <= re && rs <= e)) begin
            i++;
            continue;
         end
         keep_lo = b > rs;
         keep_hi = e < re;
         if (keep_lo && keep_hi) begin
            if (free_count >= MAX_REGIONS) return ST_FULL;
            free_len[i] = b - rs;
            put_region(i + 1, e + 1, re - e);
            i += 2;
         end else if (keep_lo) begin
            free_len[i] = b - rs;
            i++;
         end else if (keep_hi) begin
            free_base[i] = e + 1;
            free_len[i] = re - e;
            i++;
         end else begin
            drop_region(i);
         end
      end
      return ST_OK;
   endfunction

   function automatic void predict_request(req_type r);
      rsp_type x;
      bit found;
      x = '0;
      x.last = 1'b1;
      case (r.op)
         OP_ADD: begin
            x.status = add_region(r.base_addr, r.length);
            expected_rsp_q.push_back(x);
         end
         OP_EXCLUDE: begin
            x.status = exclude_range(r.base_addr, r.length);
            expected_rsp_q.push_back(x);
         end
         OP_ALLOC: begin
            found = 0;
            x.status = ST_NOFIT;
            if (r.length == 0) x.status = ST_BAD;
            else begin
               for (int i = 0; i < free_count && !found; i++) begin
                  if (free_len[i] >= r.length) begin
                     found = 1;
                     x.status = ST_OK;
                     x.alloc_addr = free_base[i];
                     if (free_len[i] == r.length) drop_region(i);
                     else begin
                        free_base[i] += r.length;
                        free_len[i] -= r.length;
                     end
                  end
               end
            end
            expected_rsp_q.push_back(x);
         end
         default: begin
            if (free_count == 0) begin
               x.status = ST_EMPTY;
               expected_rsp_q.push_back(x);
            end else begin
               for (int i = 0; i < free_count; i++) begin
                  x.status = ST_OK;
                  x.entry_base = free_base[i];
                  x.entry_size = free_len[i];
                  x.last = (i + 1 == free_count);
                  expected_rsp_q.push_back(x);
               end
            end
         end
      endcase
   endfunction

   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         free_count = 0;
         error_count = 0;
         expected_rsp_q.delete();
      end else begin
         if (rsp_valid) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response %p", $time, rsp_data);
               error_count++;
            end else begin
               want = expected_rsp_q.pop_front();
               if (rsp_data !== want) begin
                  $display("%0t: response mismatch expected %p actual %p",
                           $time, want, rsp_data);
                  error_count++;
               end
            end
         end
         if (start && !busy) predict_request(req_data);
      end
   end
endmodule

// ----- tb/region_map_first_fit_allocator_top_test.sv -----
// Stimulus and verdict for the first-fit free region table.
// Depends on rmf_pkg, the block and region_map_first_fit_allocator_checker.
`timescale 1ns / 100ps
module region_map_first_fit_allocator_top_test;
   import rmf_pkg::*;

   logic    clock = 0;
   logic    reset = 1;
   logic    start = 0;
   logic    busy;
   req_type req_data = '0;
   logic    rsp_valid;
   rsp_type rsp_data;
   int      error_count, pending_count;
   int      cycle_count = 0;
   int      burst_left = 0;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   region_map_first_fit_allocator_top dut (.*);
   region_map_first_fit_allocator_checker checker_i (.*);

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 200000) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // issue one request, with a random gap outside bursts
   task automatic send_request(logic [1:0] op, logic [31:0] b, logic [31:0] len);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 8);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         repeat (gap) @(posedge clock);
      end
      burst_left--;
      start <= 1;
      req_data <= '{op: op, base_addr: b, length: len};
      @(posedge clock);
      start <= 0;
      // busy seen here is the value of the cycle before the edge
      do @(posedge clock); while (busy);
   endtask

   function automatic logic [31:0] pick_addr();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'hFFFF_FFFF - $urandom_range(0, 300);
         default: return $urandom_range(0, 1023);
      endcase
   endfunction

   function automatic logic [31:0] pick_len();
      case ($urandom_range(0, 7))
         0: return $urandom();
         1: return 0;
         2: return 32'hFFFF_FFFF - $urandom_range(0, 3);
         default: return $urandom_range(1, 96);
      endcase
   endfunction

   initial begin
      logic [1:0] op;
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      // directed: empty table, bad ranges, overlapping adds, splits
      send_request(OP_LIST, 0, 0);
      send_request(OP_ALLOC, 0, 5);
      send_request(OP_ADD, 32'h10, 0);
      send_request(OP_ADD, 32'hFFFF_FFF0, 32'h11);
      send_request(OP_ADD, 32'hFFFF_FFF0, 32'h10);
      send_request(OP_ADD, 0, 32'hFFFF_FFF0);
      send_request(OP_EXCLUDE, 32'h100, 32'h10);
      send_request(OP_LIST, 0, 0);
      send_request(OP_ALLOC, 0, 32'hFFFF_FFF0);
      send_request(OP_ALLOC, 0, 0);
      send_request(OP_ADD, 32'h5, 32'h1);
      for (int i = 0; i < 8; i++) send_request(OP_ADD, 32'h1000 + i * 32, 16);
      send_request(OP_ADD, 32'h1004, 4);
      for (int i = 0; i < 8; i++) send_request(OP_EXCLUDE, 32'h1004 + i * 32, 4);
      send_request(OP_EXCLUDE, 32'h1002, 32'hF0);
      send_request(OP_ALLOC, 0, 16);
      send_request(OP_LIST, 0, 0);
      send_request(OP_EXCLUDE, 0, 32'hFFFF_FFFF);
      send_request(OP_EXCLUDE, 0, 0);
      send_request(OP_LIST, 0, 0);
      for (int n = 0; n < 116; n++) begin
         op = ($urandom_range(0, 9) < 4) ? OP_ADD : 2'($urandom_range(1, 3));
         send_request(op, pick_addr(), pick_len());
      end
      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (error_count == 0) $display("Simulation PASSED");
      else $display("Simulation FAILED");
      $finish;
   end
endmodule

// ----- filelist.f -----
hw/rtl/rmf_pkg.sv
hw/rtl/rmf_cell.sv
hw/rtl/region_map_first_fit_allocator_top.sv
hw/rtl/rmf_checker.sv
tb/region_map_first_fit_allocator_checker.sv
tb/region_map_first_fit_allocator_top_test.sv
